// ===== design/oev_pkg.sv =====
package oev_pkg;

    // Operation codes carried in s_axis_tuser
    localparam logic [1:0] OP_WRITE_LEVEL = 2'd0;
    localparam logic [1:0] OP_SET_DEPTH   = 2'd1;
    localparam logic [1:0] OP_SET_LAST    = 2'd2;
    localparam logic [1:0] OP_VALIDATE    = 2'd3;

    // Order types
    localparam logic [2:0] TYPE_LIMIT      = 3'd0;
    localparam logic [2:0] TYPE_MARKET     = 3'd1;
    localparam logic [2:0] TYPE_IOC        = 3'd2;
    localparam logic [2:0] TYPE_FOK        = 3'd3;
    localparam logic [2:0] TYPE_STOP       = 3'd4;
    localparam logic [2:0] TYPE_STOP_LIMIT = 3'd5;

    // Reject codes
    localparam logic [3:0] REJ_OK           = 4'd0;
    localparam logic [3:0] REJ_ID_ZERO      = 4'd1;
    localparam logic [3:0] REJ_SYMBOL_EMPTY = 4'd2;
    localparam logic [3:0] REJ_QTY_ZERO     = 4'd3;
    localparam logic [3:0] REJ_PRICE        = 4'd4;
    localparam logic [3:0] REJ_LIMIT        = 4'd5;
    localparam logic [3:0] REJ_FOK_SHORT    = 4'd6;
    localparam logic [3:0] REJ_STOP_BUY     = 4'd7;
    localparam logic [3:0] REJ_STOP_SELL    = 4'd8;
    localparam logic [3:0] REJ_SL_BUY       = 4'd9;
    localparam logic [3:0] REJ_SL_SELL      = 4'd10;

    localparam int IN_W  = 192;
    localparam int OUT_W = 72;

    // Input word, lowest field last
    typedef struct packed {
        logic [6:0]         pad;
        logic [6:0]         level_count;
        logic [5:0]         level_index;
        logic signed [31:0] limit_px;
        logic signed [31:0] price;
        logic [31:0]        quantity;
        logic [7:0]         symbol_length;
        logic [63:0]        order_id;
        logic [2:0]         order_type;
        logic               side;
    } t_in_item;

    // Result word, lowest field last
    typedef struct packed {
        logic [1:0]  pad;
        logic [31:0] shortfall;
        logic [32:0] available_quantity;
        logic [3:0]  reject_code;
        logic        accepted;
    } t_out_item;

    typedef struct packed {
        logic clear;
        logic walk;
        logic stop;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic code_ok;
        logic is_fok;
        logic is_stop;
        logic walk_done;
        logic out_free;
    } t_dp_sts;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_CHECK = 6'b000100,
        ST_WALK  = 6'b001000,
        ST_STOP  = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

endpackage

// ===== design/oev_ram.sv =====
module oev_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/oev_ctrl.sv =====
module oev_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [1:0]       i_op,
    input  oev_pkg::t_dp_sts i_sts,
    output oev_pkg::t_dp_cmd o_cmd,
    output logic             o_ready
);
    import oev_pkg::*;

    t_state r_state;
    t_state n_state;

    // Advance the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence clear pass, checks, ladder walk, stop check and result hand-off
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_accept && i_op == OP_VALIDATE) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!i_sts.code_ok) begin
                    n_state = ST_DONE;
                end else if (i_sts.is_fok) begin
                    n_state = ST_WALK;
                end else if (i_sts.is_stop) begin
                    n_state = ST_STOP;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_STOP: begin
                o_cmd.stop = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== design/oev_datapath.sv =====
module oev_datapath #(
    parameter int LADDER_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_op,
    input  oev_pkg::t_in_item i_item,
    input  oev_pkg::t_dp_cmd  i_cmd,
    output oev_pkg::t_dp_sts  o_sts,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output oev_pkg::t_out_item o_out_item
);
    import oev_pkg::*;

    localparam int AW = (LADDER_DEPTH > 1) ? $clog2(LADDER_DEPTH) : 1;
    localparam int DW = $clog2(LADDER_DEPTH + 1);

    // Ladder depths, last trade and clear sweep
    logic [DW-1:0]      r_bid_depth;
    logic [DW-1:0]      r_ask_depth;
    logic signed [31:0] r_last_trade;
    logic [AW-1:0]      r_clr_cnt;

    // Order under validation
    logic               r_sell;
    logic [2:0]         r_typ;
    logic signed [31:0] r_price;
    logic signed [31:0] r_limit;
    logic [3:0]         r_code;

    // Fill-or-kill walk
    logic [DW-1:0]      r_rd_idx;
    logic               r_pend;
    logic [32:0]        r_avail;
    logic [31:0]        r_remain;
    logic [31:0]        r_short;

    logic               r_out_valid;
    t_out_item          r_out_item;

    logic               w_wr_level;
    logic               w_idx_ok;
    logic [AW-1:0]      w_waddr;
    logic [63:0]        w_wdata;
    logic [63:0]        w_bid_rdata;
    logic [63:0]        w_ask_rdata;
    logic [63:0]        w_opp_rdata;
    logic signed [31:0] w_opp_price;
    logic [31:0]        w_opp_qty;
    logic [DW-1:0]      w_opp_depth;
    logic [DW-1:0]      w_sat_depth;
    logic [3:0]         w_precode;
    logic               w_cross;
    logic               w_filled;
    logic               w_walk_done;
    logic signed [31:0] w_ref;
    logic [3:0]         w_stop_code;

    // Decode level writes and address the ladders
    assign w_idx_ok   = {26'd0, i_item.level_index} < 32'(LADDER_DEPTH);
    assign w_wr_level = i_accept && i_op == OP_WRITE_LEVEL && w_idx_ok;
    assign w_waddr    = i_cmd.clear ? r_clr_cnt : AW'(i_item.level_index);
    assign w_wdata    = i_cmd.clear ? 64'd0 : {i_item.quantity, i_item.price};

    oev_ram #(
        .WIDTH (64),
        .DEPTH (LADDER_DEPTH)
    ) u_bid_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clear || (w_wr_level && !i_item.side)),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (w_bid_rdata)
    );

    oev_ram #(
        .WIDTH (64),
        .DEPTH (LADDER_DEPTH)
    ) u_ask_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clear || (w_wr_level && i_item.side)),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (w_ask_rdata)
    );

    // Saturate the requested depth to the ladder size
    assign w_sat_depth = ({25'd0, i_item.level_count} > 32'(LADDER_DEPTH)) ?
                         DW'(LADDER_DEPTH) : DW'(i_item.level_count);

    // Run the field checks in priority order
    always_comb begin
        if (i_item.order_id == 64'd0) begin
            w_precode = REJ_ID_ZERO;
        end else if (i_item.symbol_length == 8'd0) begin
            w_precode = REJ_SYMBOL_EMPTY;
        end else if (i_item.quantity == 32'd0) begin
            w_precode = REJ_QTY_ZERO;
        end else if (i_item.order_type != TYPE_MARKET &&
                     (i_item.price[31] || i_item.price == 32'sd0)) begin
            w_precode = REJ_PRICE;
        end else if (i_item.order_type == TYPE_STOP_LIMIT &&
                     (i_item.limit_px[31] || i_item.limit_px == 32'sd0)) begin
            w_precode = REJ_LIMIT;
        end else begin
            w_precode = REJ_OK;
        end
    end

    // Select the opposite ladder
    assign w_opp_rdata = r_sell ? w_bid_rdata : w_ask_rdata;
    assign w_opp_price = w_opp_rdata[31:0];
    assign w_opp_qty   = w_opp_rdata[63:32];
    assign w_opp_depth = r_sell ? r_bid_depth : r_ask_depth;

    // Evaluate the level returned by the previous read
    assign w_cross     = r_sell ? (w_opp_price >= r_price) : (w_opp_price <= r_price);
    assign w_filled    = r_pend && w_cross && (w_opp_qty >= r_remain);
    assign w_walk_done = r_pend ? (!w_cross || w_filled) : (r_rd_idx == w_opp_depth);

    // Compare against best opposite price, or last trade on an empty side
    assign w_ref = (w_opp_depth != '0) ? w_opp_price : r_last_trade;
    always_comb begin
        w_stop_code = REJ_OK;
        if (r_sell) begin
            if (!w_ref[31] && w_ref != 32'sd0 && r_price >= w_ref) begin
                w_stop_code = REJ_STOP_SELL;
            end else if (r_typ == TYPE_STOP_LIMIT && r_limit < r_price) begin
                w_stop_code = REJ_SL_SELL;
            end
        end else begin
            if (!w_ref[31] && w_ref != 32'sd0 && r_price <= w_ref) begin
                w_stop_code = REJ_STOP_BUY;
            end else if (r_typ == TYPE_STOP_LIMIT && r_limit > r_price) begin
                w_stop_code = REJ_SL_BUY;
            end
        end
    end

    // Hold book state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bid_depth  <= '0;
            r_ask_depth  <= '0;
            r_last_trade <= '0;
            r_clr_cnt    <= '0;
            r_out_valid  <= 1'b0;
            r_pend       <= 1'b0;
            r_rd_idx     <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (i_accept && i_op == OP_SET_DEPTH) begin
                if (i_item.side) begin
                    r_ask_depth <= w_sat_depth;
                end else begin
                    r_bid_depth <= w_sat_depth;
                end
            end
            if (i_accept && i_op == OP_SET_LAST) begin
                r_last_trade <= i_item.price;
            end
            if (i_accept && i_op == OP_VALIDATE) begin
                r_rd_idx <= '0;
                r_pend   <= 1'b0;
            end else if (i_cmd.walk && !w_walk_done) begin
                if (r_rd_idx < w_opp_depth) begin
                    r_rd_idx <= r_rd_idx + DW'(1);
                    r_pend   <= 1'b1;
                end else begin
                    r_pend   <= 1'b0;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Latch the order, accumulate the walk and record the first failure
    always_ff @(posedge i_clk) begin
        if (i_accept && i_op == OP_VALIDATE) begin
            r_sell   <= i_item.side;
            r_typ    <= i_item.order_type;
            r_price  <= i_item.price;
            r_limit  <= i_item.limit_px;
            r_code   <= w_precode;
            r_avail  <= '0;
            r_remain <= i_item.quantity;
            r_short  <= '0;
        end else if (i_cmd.walk) begin
            if (r_pend && w_cross) begin
                r_avail  <= r_avail + {1'b0, w_opp_qty};
                r_remain <= r_remain - w_opp_qty;
            end
            if (w_walk_done && !w_filled) begin
                r_code  <= REJ_FOK_SHORT;
                r_short <= r_remain;
            end
        end else if (i_cmd.stop) begin
            r_code <= w_stop_code;
        end
        if (i_cmd.out_load) begin
            r_out_item.pad                <= '0;
            r_out_item.accepted           <= (r_code == REJ_OK);
            r_out_item.reject_code        <= r_code;
            r_out_item.available_quantity <= r_avail;
            r_out_item.shortfall          <= r_short;
        end
    end

    assign o_sts.clear_last = (r_clr_cnt == AW'(LADDER_DEPTH - 1));
    assign o_sts.code_ok    = (r_code == REJ_OK);
    assign o_sts.is_fok     = (r_typ == TYPE_FOK);
    assign o_sts.is_stop    = (r_typ == TYPE_STOP) || (r_typ == TYPE_STOP_LIMIT);
    assign o_sts.walk_done  = w_walk_done;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== design/order_entry_validator.sv =====
// Order entry validator. Keeps a bid and an ask price ladder (price and quantity per level,
// LADDER_DEPTH levels, one depth per side) and a last trade price; write-level, set-depth and
// set-last-trade words update that state and give no result. A validate word gives one result
// word: the first failing check, and for fill-or-kill the crossing quantity found and the
// shortfall. The block takes no new word until a validate word has run its checks, its stop
// check or its fill-or-kill walk over the opposite levels, one read at a time through the
// single read port of each ladder memory, and has loaded its result. After reset the block
// clears both ladders, one level at a time, before it takes a word. A finished result waits
// in the output register while the next word is accepted.
module order_entry_validator #(
    parameter int LADDER_DEPTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // side, order_type, order_id, symbol_length, quantity, price, limit_px,
    // level_index, level_count, zero pad
    input  logic [oev_pkg::IN_W-1:0]  s_axis_tdata,
    // operation
    input  logic [1:0]                s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // accepted, reject_code, available_quantity, shortfall, zero pad
    output logic [oev_pkg::OUT_W-1:0] m_axis_tdata
);
    import oev_pkg::*;

    logic      w_accept;
    logic      w_ready;
    t_in_item  w_item;
    t_out_item w_out_item;
    t_dp_cmd   w_cmd;
    t_dp_sts   w_sts;

    assign w_item        = t_in_item'(s_axis_tdata);
    assign s_axis_tready = w_ready;
    assign w_accept      = s_axis_tvalid && w_ready;
    assign m_axis_tdata  = w_out_item;

    oev_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_op     (s_axis_tuser),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_ready  (w_ready)
    );

    oev_datapath #(
        .LADDER_DEPTH (LADDER_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_op        (s_axis_tuser),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_item  (w_out_item)
    );

endmodule

// ===== verif/tb_order_entry_validator.sv =====
module tb_order_entry_validator;
    import oev_pkg::*;

    localparam int LEVELS = 64;
    localparam int STALL_LIMIT = 5000;
    localparam logic [2:0] TYPE_UNDEF6 = 3'd6;
    localparam logic [2:0] TYPE_UNDEF7 = 3'd7;
    localparam logic signed [31:0] MIN_PX = 32'sh8000_0000;
    localparam logic signed [31:0] MAX_PX = 32'sh7fff_ffff;

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    // side, order_type, order_id, symbol_length, quantity, price, limit_px,
    // level_index, level_count, zero pad
    logic [IN_W-1:0]  s_axis_tdata = '0;
    // operation
    logic [1:0]       s_axis_tuser = OP_WRITE_LEVEL;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // accepted, reject_code, available_quantity, shortfall, zero pad
    logic [OUT_W-1:0] m_axis_tdata;

    // Shadow copy of both ladders, depths and last trade
    logic signed [31:0] bid_px [LEVELS];
    logic [31:0]        bid_qty [LEVELS];
    logic signed [31:0] ask_px [LEVELS];
    logic [31:0]        ask_qty [LEVELS];
    logic [6:0]         bid_dep;
    logic [6:0]         ask_dep;
    logic signed [31:0] last_px;

    t_out_item   pending_results[$];
    int          errors = 0;
    int          words_sent = 0;
    int          orders_sent = 0;
    int          idle_pct = 24;
    int          rx_hold_len = 0;
    int          rx_hold_left = 0;
    int          quiet_cycles = 0;
    logic [15:0] codes_seen = '0;

    order_entry_validator #(
        .LADDER_DEPTH(LEVELS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Work out the verdict for one order against the current ladders
    function automatic t_out_item judge_order(input t_in_item w);
        t_out_item          r;
        logic [3:0]         code;
        logic [32:0]        avail;
        logic [31:0]        shortq;
        logic signed [31:0] px, lim, lvl_px, ref_px;
        logic               filled, halted;
        int                 dep;
        r = '0;
        code = REJ_OK;
        avail = '0;
        shortq = '0;
        filled = 1'b0;
        halted = 1'b0;
        px = w.price;
        lim = w.limit_px;

        if (w.order_id == '0) code = REJ_ID_ZERO;
        else if (w.symbol_length == '0) code = REJ_SYMBOL_EMPTY;
        else if (w.quantity == '0) code = REJ_QTY_ZERO;
        else if (w.order_type != TYPE_MARKET && px <= 0) code = REJ_PRICE;
        else if (w.order_type == TYPE_STOP_LIMIT && lim <= 0) code = REJ_LIMIT;

        // Walk the opposite ladder while it crosses, until the quantity is covered
        if (code == REJ_OK && w.order_type == TYPE_FOK) begin
            dep = w.side ? int'(bid_dep) : int'(ask_dep);
            for (int i = 0; i < dep && !filled && !halted; i++) begin
                lvl_px = w.side ? bid_px[i] : ask_px[i];
                if (w.side ? (lvl_px >= px) : (lvl_px <= px)) begin
                    avail += w.side ? bid_qty[i] : ask_qty[i];
                    if (avail >= {1'b0, w.quantity}) filled = 1'b1;
                end else begin
                    halted = 1'b1;
                end
            end
            if (!filled) begin
                code = REJ_FOK_SHORT;
                shortq = w.quantity - avail[31:0];
            end
        end

        // Stop trigger against best opposite price, else last trade
        if (code == REJ_OK && (w.order_type == TYPE_STOP || w.order_type == TYPE_STOP_LIMIT))
        begin
            if (w.side) begin
                ref_px = (bid_dep != 0) ? bid_px[0] : last_px;
                if (ref_px > 0 && px >= ref_px) code = REJ_STOP_SELL;
            end else begin
                ref_px = (ask_dep != 0) ? ask_px[0] : last_px;
                if (ref_px > 0 && px <= ref_px) code = REJ_STOP_BUY;
            end
            if (code == REJ_OK && w.order_type == TYPE_STOP_LIMIT) begin
                if (!w.side && lim > px) code = REJ_SL_BUY;
                else if (w.side && lim < px) code = REJ_SL_SELL;
            end
        end

        r.accepted = (code == REJ_OK);
        r.reject_code = code;
        r.available_quantity = avail;
        r.shortfall = shortq;
        return r;
    endfunction

    // Apply one accepted word to the shadow book, or queue its verdict
    task automatic book_step(input logic [1:0] op, input t_in_item w);
        case (op)
            OP_WRITE_LEVEL: begin
                if (w.side) begin
                    ask_px[w.level_index] = w.price;
                    ask_qty[w.level_index] = w.quantity;
                end else begin
                    bid_px[w.level_index] = w.price;
                    bid_qty[w.level_index] = w.quantity;
                end
            end
            OP_SET_DEPTH: begin
                if (w.side) ask_dep = (w.level_count > LEVELS) ? 7'(LEVELS) : w.level_count;
                else bid_dep = (w.level_count > LEVELS) ? 7'(LEVELS) : w.level_count;
            end
            OP_SET_LAST: last_px = w.price;
            default: begin
                pending_results.push_back(judge_order(w));
                orders_sent++;
            end
        endcase
    endtask

    // Offer one word, with random gaps, and hold it until taken
    task automatic send_word(input logic [1:0] op, input t_in_item w);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        book_step(op, w);
        words_sent++;
    endtask

    // Stop offering and wait for every outstanding verdict
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in_item mk_order(input logic [2:0] kind, input logic sd,
                                          input logic [31:0] qty, input logic signed [31:0] px,
                                          input logic signed [31:0] lim);
        t_in_item w;
        w = '0;
        w.order_type = kind;
        w.side = sd;
        w.order_id = '1;
        w.symbol_length = '1;
        w.quantity = qty;
        w.price = px;
        w.limit_px = lim;
        return w;
    endfunction

    function automatic t_in_item mk_book(input logic sd, input logic [5:0] idx,
                                         input logic [6:0] cnt, input logic signed [31:0] px,
                                         input logic [31:0] qty);
        t_in_item w;
        w = '0;
        w.side = sd;
        w.level_index = idx;
        w.level_count = cnt;
        w.price = px;
        w.quantity = qty;
        return w;
    endfunction

    function automatic t_in_item noise_word();
        t_in_item w;
        w = '0;
        w.side = 1'($urandom);
        w.order_type = 3'($urandom);
        w.order_id = {$urandom, $urandom};
        w.symbol_length = 8'($urandom);
        w.quantity = $urandom;
        w.price = $urandom;
        w.limit_px = $urandom;
        w.level_index = 6'($urandom);
        w.level_count = 7'($urandom);
        return w;
    endfunction

    // Mostly well-formed order priced around the ladder, with some broken fields
    function automatic t_in_item rand_order(input logic signed [31:0] base, input int step);
        t_in_item w;
        int       pick;
        w = noise_word();
        pick = $urandom_range(9);
        if (pick < 3) w.order_type = TYPE_FOK;
        else if (pick < 5) w.order_type = TYPE_STOP;
        else if (pick < 7) w.order_type = TYPE_STOP_LIMIT;

        if ($urandom_range(24) == 0) w.order_id = '0;
        else if (w.order_id == '0) w.order_id = 64'd1;
        if ($urandom_range(24) == 0) w.symbol_length = '0;
        else if (w.symbol_length == '0) w.symbol_length = 8'd1;

        pick = $urandom_range(19);
        if (pick == 0) w.quantity = '0;
        else if (pick > 2) w.quantity = $urandom_range(1, 120);

        pick = $urandom_range(19);
        if (pick > 3) begin
            w.price = w.side ? base - (int'($urandom_range(0, 12)) - 3) * step
                             : base + (int'($urandom_range(0, 12)) - 3) * step;
        end else if (pick == 3) begin
            w.price = w.side ? base - 80 * step : base + 80 * step;
        end else if (pick == 0) begin
            w.price = 32'sd0;
        end else if (pick == 1) begin
            w.price = -int'($urandom_range(1, 1000));
        end

        pick = $urandom_range(9);
        if (pick > 1) w.limit_px = w.price + (int'($urandom_range(0, 6)) - 3);
        else if (pick == 0) w.limit_px = $urandom_range(1) ? 32'sd0 : -32'sd7;
        return w;
    endfunction

    // Rebuild one ladder side, then validate orders against it
    task automatic book_episode(input int n_orders);
        t_in_item           w;
        logic               sd;
        int                 nlev, step, pick;
        logic signed [31:0] base;
        sd = 1'($urandom);
        nlev = ($urandom_range(9) == 0) ? LEVELS : $urandom_range(8);
        step = $urandom_range(1, 5);
        base = $urandom_range(50, 2000);
        for (int i = 0; i < nlev; i++) begin
            w = noise_word();
            w.side = sd;
            w.level_index = 6'(i);
            w.price = sd ? base - i * step : base + i * step;
            pick = $urandom_range(9);
            if (pick == 0) w.quantity = '0;
            else if (pick > 1) w.quantity = $urandom_range(1, 50);
            send_word(OP_WRITE_LEVEL, w);
        end
        w = noise_word();
        w.side = sd;
        if ($urandom_range(7) != 0) w.level_count = 7'(nlev);
        send_word(OP_SET_DEPTH, w);
        if ($urandom_range(3) == 0) begin
            w = noise_word();
            if ($urandom_range(3) != 0) w.price = base + (int'($urandom_range(0, 8)) - 4) * step;
            send_word(OP_SET_LAST, w);
        end
        for (int i = 0; i < n_orders; i++) send_word(OP_VALIDATE, rand_order(base, step));
    endtask

    // Each check in order, stop references and fill-or-kill walk endings
    task automatic test_reject_paths();
        t_in_item w;
        w = mk_order(TYPE_LIMIT, 1'b0, 32'd5, 32'sd100, 32'sd0);
        w.order_id = '0;
        send_word(OP_VALIDATE, w);
        w = mk_order(TYPE_LIMIT, 1'b1, 32'd5, 32'sd100, 32'sd0);
        w.symbol_length = '0;
        send_word(OP_VALIDATE, w);
        send_word(OP_VALIDATE, mk_order(TYPE_LIMIT, 1'b0, 32'd0, 32'sd100, 32'sd0));
        send_word(OP_VALIDATE, mk_order(TYPE_LIMIT, 1'b0, 32'd1, 32'sd0, 32'sd0));
        send_word(OP_VALIDATE, mk_order(TYPE_IOC, 1'b1, 32'd1, MIN_PX, 32'sd0));
        // market skips the price check
        send_word(OP_VALIDATE, mk_order(TYPE_MARKET, 1'b0, '1, MIN_PX, MIN_PX));
        send_word(OP_VALIDATE, mk_order(TYPE_STOP_LIMIT, 1'b0, 32'd1, 32'sd10, -32'sd1));
        // undefined types behave as priced limit orders
        send_word(OP_VALIDATE, mk_order(TYPE_UNDEF6, 1'b0, 32'd1, MAX_PX, 32'sd0));
        send_word(OP_VALIDATE, mk_order(TYPE_UNDEF7, 1'b1, 32'd1, 32'sd0, 32'sd0));
        // fill-or-kill into an empty ask side
        send_word(OP_VALIDATE, mk_order(TYPE_FOK, 1'b0, '1, MAX_PX, 32'sd0));

        send_word(OP_WRITE_LEVEL, mk_book(1'b1, 6'd0, 7'd0, 32'sd100, 32'd10));
        send_word(OP_WRITE_LEVEL, mk_book(1'b1, 6'd1, 7'd0, 32'sd101, 32'd20));
        send_word(OP_WRITE_LEVEL, mk_book(1'b1, 6'd2, 7'd0, 32'sd105, 32'd30));
        send_word(OP_WRITE_LEVEL, mk_book(1'b1, 6'd63, 7'd0, MAX_PX, '1));
        send_word(OP_SET_DEPTH, mk_book(1'b1, 6'd0, 7'd3, 32'sd0, 32'd0));
        // covered, stopped at a non-crossing level, and ran out of depth
        send_word(OP_VALIDATE, mk_order(TYPE_FOK, 1'b0, 32'd25, 32'sd102, 32'sd0));
        send_word(OP_VALIDATE, mk_order(TYPE_FOK, 1'b0, 32'd40, 32'sd102, 32'sd0));
        send_word(OP_VALIDATE, mk_order(TYPE_FOK, 1'b0, 32'd100, 32'sd200, 32'sd0));

        send_word(OP_VALIDATE, mk_order(TYPE_STOP, 1'b0, 32'd1, 32'sd100, 32'sd0));
        send_word(OP_VALIDATE, mk_order(TYPE_STOP_LIMIT, 1'b0, 32'd1, 32'sd101, 32'sd102));
        send_word(OP_VALIDATE, mk_order(TYPE_STOP_LIMIT, 1'b0, 32'd1, 32'sd101, 32'sd101));
        // empty bid side falls back to last trade
        send_word(OP_SET_LAST, mk_book(1'b0, 6'd0, 7'd0, 32'sd50, 32'd0));
        send_word(OP_VALIDATE, mk_order(TYPE_STOP, 1'b1, 32'd1, 32'sd50, 32'sd0));
        send_word(OP_VALIDATE, mk_order(TYPE_STOP_LIMIT, 1'b1, 32'd1, 32'sd49, 32'sd48));
        // negative reference skips the trigger check
        send_word(OP_SET_LAST, mk_book(1'b0, 6'd0, 7'd0, -32'sd5, 32'd0));
        send_word(OP_VALIDATE, mk_order(TYPE_STOP, 1'b1, 32'd1, 32'sd10, 32'sd0));
        // oversize depth saturates to the ladder size
        send_word(OP_SET_DEPTH, mk_book(1'b0, 6'd0, 7'd127, 32'sd0, 32'd0));
        send_word(OP_WRITE_LEVEL, mk_book(1'b0, 6'd0, 7'd0, MAX_PX, '1));
        send_word(OP_VALIDATE, mk_order(TYPE_FOK, 1'b1, '1, 32'sd1, 32'sd0));
        wait_drain();
    endtask

    // Hold the result side off while orders keep coming
    task automatic test_output_stall();
        rx_hold_len = 400;
        book_episode(40);
        wait_drain();
    endtask

    task automatic test_random_book(input int n_words);
        t_in_item w;
        int       stop_at;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            if ($urandom_range(7) == 0) begin
                for (int i = 0; i < 5; i++) send_word(2'($urandom_range(3)), noise_word());
            end else begin
                book_episode($urandom_range(3, 16));
            end
        end
        wait_drain();
    endtask

    task automatic test_back_to_back(input int n_words);
        idle_pct = 0;
        test_random_book(n_words);
        idle_pct = 24;
    endtask

    // Result side: random stalls, plus a long hold when requested
    always @(posedge i_clk) begin
        if (rx_hold_len != 0) begin
            rx_hold_left = rx_hold_len;
            rx_hold_len = 0;
        end
        if (!i_rst_n || rx_hold_left != 0) begin
            m_axis_tready <= 1'b0;
            if (rx_hold_left != 0) rx_hold_left--;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Compare each result word with the oldest predicted verdict
    always @(posedge i_clk) begin : check_result
        t_out_item got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_results.size() == 0) begin
                $error("result word with no order pending: reject_code %0d", got.reject_code);
                errors++;
            end else begin
                want = pending_results.pop_front();
                codes_seen[want.reject_code] = 1'b1;
                if (got.accepted !== want.accepted) begin
                    $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                    errors++;
                end
                if (got.reject_code !== want.reject_code) begin
                    $error("reject_code: expected %0d, got %0d",
                           want.reject_code, got.reject_code);
                    errors++;
                end
                if (got.available_quantity !== want.available_quantity) begin
                    $error("available_quantity: expected %0d, got %0d",
                           want.available_quantity, got.available_quantity);
                    errors++;
                end
                if (got.shortfall !== want.shortfall) begin
                    $error("shortfall: expected %0d, got %0d", want.shortfall, got.shortfall);
                    errors++;
                end
            end
        end
    end

    // End the run when nothing moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < LEVELS; i++) begin
            bid_px[i] = '0;
            bid_qty[i] = '0;
            ask_px[i] = '0;
            ask_qty[i] = '0;
        end
        bid_dep = '0;
        ask_dep = '0;
        last_px = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reject_paths();
        test_output_stall();
        test_random_book(700);
        test_back_to_back(150);

        wait_drain();
        repeat (LEVELS + 10) @(posedge i_clk);
        $display("Drove %0d words, %0d of them order checks, over ladders up to %0d levels;",
                 words_sent, orders_sent, LEVELS);
        $display("%0d of 11 verdict codes came up, with a long result stall and a no-gap stretch.",
                 $countones(codes_seen));
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
